FILE: design/tcdw_pkg.sv
// ----------------------------------------------------------------------------
// tcdw_pkg
// Types, codes and defaults shared by the two-class deadline WRR scheduler.
// ----------------------------------------------------------------------------
package tcdw_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int CLASS_COUNT     = 2;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 40;

	localparam logic [1:0] CMD_ENQ    = 2'd0;
	localparam logic [1:0] CMD_DEQ    = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam logic [2:0] STS_ENQUEUED = 3'd0;
	localparam logic [2:0] STS_GRANTED  = 3'd1;
	localparam logic [2:0] STS_EMPTY    = 3'd2;
	localparam logic [2:0] STS_FULL     = 3'd3;
	localparam logic [2:0] STS_FINISHED = 3'd4;

	localparam logic [1:0] MODE_STRICT    = 2'd0;
	localparam logic [1:0] MODE_RR        = 2'd1;
	localparam logic [1:0] MODE_DL_STRICT = 2'd2;
	localparam logic [1:0] MODE_DL_RR     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_H = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_L = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WAIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WAIT_FACT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DL_GAP    = 3'd5;

	localparam logic [7:0]  QUANTUM_H_RST = 8'd10;
	localparam logic [7:0]  QUANTUM_L_RST = 8'd1;
	localparam logic [39:0] HIGH_WAIT_RST = 40'd5000000000;
	localparam logic [31:0] WAIT_FACT_RST = 32'd65536;
	localparam logic [47:0] MASK48        = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] MASK32        = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  command;
		logic [47:0] now;
		logic        req_class;
		logic [19:0] req_count;
		logic [15:0] req_tag;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] grant_tag;
		logic        grant_class;
		logic [19:0] grant_count;
		logic [47:0] assigned_deadline;
	} out_t;

	typedef struct packed {
		logic [47:0] deadline;
		logic [19:0] count;
		logic [15:0] tag;
	} entry_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic capture;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic drop;
		logic needs_wait;
		logic out_free;
	} dp_status_t;

endpackage

FILE: design/two_class_deadline_wrr_scheduler_unit.sv
// Enqueue and finish pass through accept, issue and commit; a dequeue with a
// non-empty queue adds a capture step (one RAM read per queue head through the
// single registered read port). A new transaction is taken only once the
// previous one commits into the output register, which may still wait on out_ready.
// Reset: arst_n clears pointers, counters, round robin state and registers to
// defaults; the entry RAM is not cleared, entries are used only after written.
// ----------------------------------------------------------------------------
// two_class_deadline_wrr_scheduler_unit
// Two-class I/O request scheduler with deadlines and weighted round robin.
// ----------------------------------------------------------------------------
module two_class_deadline_wrr_scheduler_unit
	import tcdw_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	ctrl_cmd_t  cmd;
	dp_status_t sts;

	tcdw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcdw_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule

FILE: design/tcdw_ram.sv
// ----------------------------------------------------------------------------
// tcdw_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcdw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: design/tcdw_ctrl.sv
// ----------------------------------------------------------------------------
// tcdw_ctrl
// Sequencer: accept, issue head reads, capture, commit one transaction.
// ----------------------------------------------------------------------------
module tcdw_ctrl
	import tcdw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t sts,
	output ctrl_cmd_t  cmd
);
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAITH = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				if (sts.drop) state_d = ST_IDLE;
				else if (sts.needs_wait) state_d = ST_WAITH;
				else state_d = ST_FIN;
			end
			ST_WAITH: begin
				cmd.capture = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign in_ready = (state_q == ST_IDLE);

	a_commit_fin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> state_q == ST_FIN)
		else $error("commit outside final state");
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_ISSUE)
		else $error("accepted transaction not issued");
	a_capture_prev: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> $past(cmd.issue))
		else $error("capture without issue");
endmodule

FILE: design/tcdw_dp.sv
// ----------------------------------------------------------------------------
// tcdw_dp
// Datapath: queue pointers, byte counters, deadline math, class selection.
// ----------------------------------------------------------------------------
module tcdw_dp
	import tcdw_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_t                   in_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output out_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            sts
);
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(2 * QUEUE_DEPTH);
	localparam int EW = $bits(entry_t);

	in_t           in_q;
	logic [PW-1:0] head_q [CLASS_COUNT];
	logic [FW-1:0] fill_q [CLASS_COUNT];
	logic [31:0]   bq_q, bis_q;
	logic          turn_q;
	logic [7:0]    ql_q [CLASS_COUNT];
	logic [1:0]    mode_q;
	logic [7:0]    qh_q, qlo_q;
	logic [39:0]   hcw_q;
	logic [31:0]   wf_q, gap_q;
	logic [48:0]   p1_q, p2_q;
	entry_t        hh_q;
	out_t          out_q;
	out_t          out_d;
	logic          out_valid_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	entry_t        wentry, rentry;
	logic [EW-1:0] rbits;

	function automatic logic [PW-1:0] wrap(input logic [PW:0] v);
		logic [PW:0] qd;
		qd = (PW+1)'(QUEUE_DEPTH);
		return (v >= qd) ? PW'(v - qd) : PW'(v);
	endfunction

	function automatic logic [AW-1:0] addr(input logic c, input logic [PW-1:0] idx);
		return c ? AW'(QUEUE_DEPTH) + AW'(idx) : AW'(idx);
	endfunction

	function automatic logic [47:0] sat48(input logic [50:0] v);
		return (v > 51'(MASK48)) ? MASK48 : v[47:0];
	endfunction

	function automatic logic [31:0] sat32(input logic [32:0] v);
		return v[32] ? MASK32 : v[31:0];
	endfunction

	function automatic logic [31:0] sub0(input logic [31:0] a, input logic [31:0] b);
		return (a > b) ? a - b : 32'd0;
	endfunction

	tcdw_ram #(.WIDTH(EW), .DEPTH(2 * QUEUE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wentry),
		.re    (re),
		.raddr (raddr),
		.rdata (rbits)
	);
	assign rentry = entry_t'(rbits);

	// read sequencing
	logic [PW-1:0] lo_last;
	always_comb begin
		lo_last = wrap((PW+1)'(head_q[0]) + (PW+1)'(fill_q[0]) - (PW+1)'(1));
		re      = cmd.issue | cmd.capture;
		if (cmd.capture) raddr = addr(1'b0, head_q[0]);
		else if (in_q.command == CMD_DEQ) raddr = addr(1'b1, head_q[1]);
		else raddr = addr(1'b0, lo_last);
	end

	logic both_empty, full;
	assign both_empty     = (fill_q[0] == '0) && (fill_q[1] == '0);
	assign full           = (fill_q[in_q.req_class] == FW'(QUEUE_DEPTH));
	assign sts.drop       = (in_q.command != CMD_ENQ) && (in_q.command != CMD_DEQ)
	                        && (in_q.command != CMD_FINISH);
	assign sts.needs_wait = (in_q.command == CMD_DEQ) && !both_empty;
	assign sts.out_free   = !out_valid_q || out_ready;

	// low-class wait products, split on the Q16 point
	logic [32:0] sum33;
	assign sum33 = 33'(bq_q) + 33'(bis_q);

	// enqueue deadline
	logic [49:0] wait50;
	logic [47:0] low_dl, high_dl, enq_dl;
	always_comb begin
		wait50  = 50'(p1_q) + 50'(p2_q[48:16]);
		low_dl  = sat48(51'(in_q.now) + 51'(wait50));
		if (fill_q[0] != '0 && rentry.deadline > low_dl)
			low_dl = sat48(51'(rentry.deadline) + 51'(gap_q));
		high_dl = sat48(51'(in_q.now) + 51'(hcw_q));
		enq_dl  = in_q.req_class ? high_dl : low_dl;
	end

	// dequeue class choice
	logic          sel, turn_d, rr_c;
	logic [7:0]    ql_d [CLASS_COUNT];
	logic          expired_h, expired_l, dl_mode, rr_mode;
	entry_t        sel_e;
	always_comb begin
		dl_mode   = (mode_q == MODE_DL_STRICT) || (mode_q == MODE_DL_RR);
		rr_mode   = (mode_q == MODE_RR) || (mode_q == MODE_DL_RR);
		expired_h = (fill_q[1] != '0) && (hh_q.deadline < in_q.now);
		expired_l = (fill_q[0] != '0) && (rentry.deadline < in_q.now);
		ql_d[0]   = ql_q[0];
		ql_d[1]   = ql_q[1];
		turn_d    = turn_q;
		rr_c      = turn_q;
		if (fill_q[rr_c] == '0) begin
			ql_d[rr_c] = rr_c ? qh_q : qlo_q;
			rr_c       = ~rr_c;
		end
		if (ql_d[rr_c] <= 8'd1) begin
			ql_d[rr_c] = rr_c ? qh_q : qlo_q;
			turn_d     = ~rr_c;
		end else begin
			ql_d[rr_c] = ql_d[rr_c] - 8'd1;
			turn_d     = rr_c;
		end
		if (dl_mode && expired_h) sel = 1'b1;
		else if (dl_mode && expired_l) sel = 1'b0;
		else if (rr_mode) sel = rr_c;
		else sel = (fill_q[1] != '0);
		sel_e = sel ? hh_q : rentry;
	end

	logic rr_used;
	assign rr_used = rr_mode && !(dl_mode && (expired_h || expired_l));

	always_comb begin
		we          = cmd.commit && (in_q.command == CMD_ENQ) && !full;
		waddr       = addr(in_q.req_class, wrap((PW+1)'(head_q[in_q.req_class])
		              + (PW+1)'(fill_q[in_q.req_class])));
		wentry      = '{deadline: enq_dl, count: in_q.req_count, tag: in_q.req_tag};
	end

	// result of the transaction in flight
	always_comb begin
		out_d = '0;
		case (in_q.command)
			CMD_ENQ: begin
				if (full) out_d.status = STS_FULL;
				else begin
					out_d.status            = STS_ENQUEUED;
					out_d.assigned_deadline = enq_dl;
				end
			end
			CMD_DEQ: begin
				if (both_empty) out_d.status = STS_EMPTY;
				else begin
					out_d.status            = STS_GRANTED;
					out_d.grant_tag         = sel_e.tag;
					out_d.grant_class       = sel;
					out_d.grant_count       = sel_e.count;
					out_d.assigned_deadline = sel_e.deadline;
				end
			end
			default: out_d.status = STS_FINISHED;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) in_q <= in_data;
		if (cmd.issue) begin
			p1_q <= 49'(sum33) * 49'(wf_q[31:16]);
			p2_q <= 49'(sum33) * 49'(wf_q[15:0]);
		end
		if (cmd.capture) hh_q <= rentry;
		if (cmd.commit) out_q <= out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '{default: '0};
			fill_q      <= '{default: '0};
			bq_q        <= '0;
			bis_q       <= '0;
			turn_q      <= 1'b1;
			ql_q[0]     <= QUANTUM_L_RST;
			ql_q[1]     <= QUANTUM_H_RST;
			mode_q      <= MODE_STRICT;
			qh_q        <= QUANTUM_H_RST;
			qlo_q       <= QUANTUM_L_RST;
			hcw_q       <= HIGH_WAIT_RST;
			wf_q        <= WAIT_FACT_RST;
			gap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.commit || (out_valid_q && !out_ready);
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MODE:      mode_q <= cfg_data[1:0];
					CFG_QUANTUM_H: qh_q   <= cfg_data[7:0];
					CFG_QUANTUM_L: qlo_q  <= cfg_data[7:0];
					CFG_HIGH_WAIT: hcw_q  <= cfg_data;
					CFG_WAIT_FACT: wf_q   <= cfg_data[31:0];
					CFG_DL_GAP:    gap_q  <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (cmd.commit) begin
				case (in_q.command)
					CMD_ENQ: begin
						if (!full) begin
							fill_q[in_q.req_class] <= fill_q[in_q.req_class] + FW'(1);
							bq_q <= sat32(33'(bq_q) + 33'(in_q.req_count));
						end
					end
					CMD_DEQ: begin
						if (!both_empty) begin
							head_q[sel] <= wrap((PW+1)'(head_q[sel]) + (PW+1)'(1));
							fill_q[sel] <= fill_q[sel] - FW'(1);
							bq_q        <= sub0(bq_q, 32'(sel_e.count));
							bis_q       <= sat32(33'(bis_q) + 33'(sel_e.count));
							if (rr_used) begin
								turn_q  <= turn_d;
								ql_q[0] <= ql_d[0];
								ql_q[1] <= ql_d[1];
							end
						end
					end
					default: bis_q <= sub0(bis_q, 32'(in_q.req_count));
				endcase
			end
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_fill_lo: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[0] <= FW'(QUEUE_DEPTH))
		else $error("low queue overfilled");
	a_fill_hi: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[1] <= FW'(QUEUE_DEPTH))
		else $error("high queue overfilled");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before taken");
	a_grant_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && in_q.command == CMD_DEQ && !both_empty) |-> fill_q[sel] != '0)
		else $error("grant from empty queue");
endmodule
